### design/sfs_pkg.sv
// Shared types, codes and character constants for the scanf field scanner.
package sfs_pkg;

  localparam int VALUE_BITS_DEF    = 32;
  localparam int DEFAULT_WIDTH_DEF = 30000;

  localparam int CH_W    = 7;
  localparam int OUT_W   = 32;
  localparam int WIDTH_W = 15;
  localparam int SET_W   = 64;
  localparam int IDX_W   = 3;
  localparam int KIND_W  = 3;
  localparam int SIZE_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FIELD_KIND = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_STORE_SIZE = 3'd2;
  localparam logic [IDX_W-1:0] REG_SUPPRESS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SET_LOW    = 3'd4;
  localparam logic [IDX_W-1:0] REG_SET_HIGH   = 3'd5;

  // field kinds; the two unused codes scan as decimal
  localparam logic [KIND_W-1:0] KIND_DEC     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OCT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HEX     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STRING  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SCANSET = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_SHORT = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_INT   = 2'd1;

  // character codes
  localparam logic [CH_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 7'h09;
  localparam logic [CH_W-1:0] CH_NL    = 7'h0A;
  localparam logic [CH_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 7'h39;
  localparam logic [CH_W-1:0] CH_LA    = 7'h61;
  localparam logic [CH_W-1:0] CH_LF    = 7'h66;
  localparam logic [CH_W-1:0] CH_UA    = 7'h41;
  localparam logic [CH_W-1:0] CH_UF    = 7'h46;
  localparam logic [CH_W-1:0] CH_LA_OFS = 7'h57;  // 'a' - 10
  localparam logic [CH_W-1:0] CH_UA_OFS = 7'h37;  // 'A' - 10

  typedef struct packed {
    logic [KIND_W-1:0]  field_kind;
    logic [WIDTH_W-1:0] max_width;
    logic [SIZE_W-1:0]  store_size;
    logic               suppress_store;
    logic [SET_W-1:0]   set_low;
    logic [SET_W-1:0]   set_high;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]         out_char;
    logic                    char_stored;
    logic                    consumed;
    logic                    field_done;
    logic                    matched;
    logic signed [OUT_W-1:0] value;
    logic                    at_eof;
  } res_t;

endpackage

### design/sfs_in_if.sv
// Input character channel of the scanf field scanner.
interface sfs_in_if;
  logic                       valid;
  logic                       ready;
  logic [sfs_pkg::CH_W-1:0]   ch;
  logic                       is_eof;

  modport source (output valid, output ch, output is_eof, input ready);
  modport sink   (input valid, input ch, input is_eof, output ready);
endinterface

### design/sfs_out_if.sv
// Result channel of the scanf field scanner.
interface sfs_out_if;
  logic                              valid;
  logic                              ready;
  logic [sfs_pkg::CH_W-1:0]          out_char;
  logic                              char_stored;
  logic                              consumed;
  logic                              field_done;
  logic                              matched;
  logic signed [sfs_pkg::OUT_W-1:0]  value;
  logic                              at_eof;

  modport source (output valid, output out_char, output char_stored, output consumed,
                  output field_done, output matched, output value, output at_eof,
                  input ready);
  modport sink   (input valid, input out_char, input char_stored, input consumed,
                  input field_done, input matched, input value, input at_eof,
                  output ready);
endinterface

### design/scanf_field_scanner.sv
// Top level of the scanf field scanner: input register, step logic, result register.
// Path: a character passes from the input register through the step logic into the result register.
// Throughput: one character per cycle while results are taken; the step logic is a combinational shift-add.
// Ready stalls only when both the input and result registers hold undelivered items.
// Reset: asynchronous active low; registers return to their reset values, store_size
// resets to int, and the scanner starts a new field by skipping leading whitespace.
module scanf_field_scanner #(
  parameter int VALUE_BITS    = sfs_pkg::VALUE_BITS_DEF,
  parameter int DEFAULT_WIDTH = sfs_pkg::DEFAULT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfs_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [sfs_pkg::SET_W-1:0]   cfg_wdata_i,
  sfs_in_if.sink                      in_i,
  sfs_out_if.source                   out_o
);

  sfs_pkg::cfg_t cfg;
  logic          restart;

  // input register
  logic                     in_vld_q;
  logic [sfs_pkg::CH_W-1:0] ch_q;
  logic                     eof_q;

  // result register
  logic          out_vld_q;
  sfs_pkg::res_t res_q;
  sfs_pkg::res_t res;

  logic out_free, step_fire;

  // result slot frees when empty or its transaction completes this cycle
  assign out_free  = !out_vld_q || out_o.ready;
  assign step_fire = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || out_free;

  sfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  sfs_step #(
    .VALUE_BITS    (VALUE_BITS),
    .DEFAULT_WIDTH (DEFAULT_WIDTH)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_fire),
    .restart_i (restart),
    .cfg_i     (cfg),
    .ch_i      (ch_q),
    .is_eof_i  (eof_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (step_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q  <= in_i.ch;
      eof_q <= in_i.is_eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_char    = res_q.out_char;
  assign out_o.char_stored = res_q.char_stored;
  assign out_o.consumed    = res_q.consumed;
  assign out_o.field_done  = res_q.field_done;
  assign out_o.matched     = res_q.matched;
  assign out_o.value       = res_q.value;
  assign out_o.at_eof      = res_q.at_eof;

endmodule

### design/sfs_cfg.sv
// Configuration register file with field restart on every valid write.
module sfs_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfs_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [sfs_pkg::SET_W-1:0]   cfg_wdata_i,
  output sfs_pkg::cfg_t               cfg_o,
  output logic                        restart_o
);

  sfs_pkg::cfg_t cfg_q, cfg_d;
  logic          hit;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      hit = 1'b1;
      case (cfg_idx_i)
        sfs_pkg::REG_FIELD_KIND: cfg_d.field_kind = cfg_wdata_i[sfs_pkg::KIND_W-1:0];
        sfs_pkg::REG_MAX_WIDTH:  cfg_d.max_width  = cfg_wdata_i[sfs_pkg::WIDTH_W-1:0];
        sfs_pkg::REG_STORE_SIZE: cfg_d.store_size = cfg_wdata_i[sfs_pkg::SIZE_W-1:0];
        sfs_pkg::REG_SUPPRESS:   cfg_d.suppress_store = cfg_wdata_i[0];
        sfs_pkg::REG_SET_LOW:    cfg_d.set_low    = cfg_wdata_i;
        sfs_pkg::REG_SET_HIGH:   cfg_d.set_high   = cfg_wdata_i;
        default:                 hit = 1'b0;  // no register there
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{field_kind: '0, max_width: '0, store_size: sfs_pkg::SIZE_INT,
                 suppress_store: 1'b0, set_low: '0, set_high: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = hit;

endmodule

### design/sfs_step.sv
// Field scan state and the per-character step logic.
module sfs_step #(
  parameter int VALUE_BITS    = sfs_pkg::VALUE_BITS_DEF,
  parameter int DEFAULT_WIDTH = sfs_pkg::DEFAULT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_en_i,
  input  logic                        restart_i,
  input  sfs_pkg::cfg_t               cfg_i,
  input  logic [sfs_pkg::CH_W-1:0]    ch_i,
  input  logic                        is_eof_i,
  output sfs_pkg::res_t               res_o
);

  localparam int WW = sfs_pkg::WIDTH_W;

  logic                  body_q, body_d;
  logic [WW-1:0]         wl_q, wl_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic                  any_q, any_d;

  logic                  strkind, is_sp, in_set, lead_skip, sign_ch;
  logic [WW-1:0]         wl_load, wl, wl_str;
  logic                  dig_ok;
  logic [3:0]            dig;
  logic [VALUE_BITS-1:0] acc_mul, acc_neg;
  logic [VALUE_BITS+sfs_pkg::OUT_W-1:0] v_wide;
  logic [sfs_pkg::OUT_W-1:0] v32;
  logic [2*sfs_pkg::SET_W-1:0] set_all;
  logic                  restart_field;

  // digit classification: 8 and 9 stay legal in octal
  always_comb begin
    dig_ok = 1'b0;
    dig    = '0;
    if (ch_i >= sfs_pkg::CH_ZERO && ch_i <= sfs_pkg::CH_NINE) begin
      dig_ok = 1'b1;
      dig    = 4'(ch_i - sfs_pkg::CH_ZERO);
    end else if (cfg_i.field_kind == sfs_pkg::KIND_HEX) begin
      if (ch_i >= sfs_pkg::CH_LA && ch_i <= sfs_pkg::CH_LF) begin
        dig_ok = 1'b1;
        dig    = 4'(ch_i - sfs_pkg::CH_LA_OFS);
      end else if (ch_i >= sfs_pkg::CH_UA && ch_i <= sfs_pkg::CH_UF) begin
        dig_ok = 1'b1;
        dig    = 4'(ch_i - sfs_pkg::CH_UA_OFS);
      end
    end
  end

  // base multiply as shifts and adds
  always_comb begin
    case (cfg_i.field_kind)
      sfs_pkg::KIND_OCT: acc_mul = acc_q << 3;
      sfs_pkg::KIND_HEX: acc_mul = acc_q << 4;
      default:           acc_mul = (acc_q << 3) + (acc_q << 1);
    endcase
  end

  // final value: sign, truncation to 32 bits, short sign extension
  always_comb begin
    acc_neg = neg_q ? (~acc_q + 1'b1) : acc_q;
    v_wide  = {{sfs_pkg::OUT_W{1'b0}}, acc_neg};
    v32     = v_wide[sfs_pkg::OUT_W-1:0];
    if (cfg_i.store_size == sfs_pkg::SIZE_SHORT) begin
      v32 = {{16{v32[15]}}, v32[15:0]};
    end
  end

  assign strkind = (cfg_i.field_kind == sfs_pkg::KIND_CHAR) ||
                   (cfg_i.field_kind == sfs_pkg::KIND_STRING) ||
                   (cfg_i.field_kind == sfs_pkg::KIND_SCANSET);
  assign is_sp   = (ch_i == sfs_pkg::CH_SPACE) || (ch_i == sfs_pkg::CH_TAB) ||
                   (ch_i == sfs_pkg::CH_NL);
  assign set_all = {cfg_i.set_high, cfg_i.set_low};
  assign in_set  = set_all[ch_i];
  assign lead_skip = !body_q && !is_eof_i && is_sp &&
                     (!strkind || cfg_i.field_kind == sfs_pkg::KIND_STRING);
  assign sign_ch = !strkind && !is_eof_i &&
                   (ch_i == sfs_pkg::CH_MINUS || ch_i == sfs_pkg::CH_PLUS);

  always_comb begin
    if (cfg_i.max_width != '0)                       wl_load = cfg_i.max_width;
    else if (cfg_i.field_kind == sfs_pkg::KIND_CHAR) wl_load = WW'(1);
    else                                             wl_load = WW'(DEFAULT_WIDTH);
  end

  assign wl     = body_q ? wl_q : wl_load;
  assign wl_str = (wl != '0) ? (wl - 1'b1) : '0;

  always_comb begin
    res_o         = '0;
    body_d        = body_q;
    wl_d          = wl_q;
    acc_d         = acc_q;
    neg_d         = neg_q;
    any_d         = any_q;
    restart_field = 1'b0;
    if (lead_skip) begin
      res_o.consumed = 1'b1;
    end else if (!body_q && sign_ch) begin
      body_d         = 1'b1;
      wl_d           = wl_load - 1'b1;
      res_o.consumed = 1'b1;
      if (ch_i == sfs_pkg::CH_MINUS) begin
        neg_d = 1'b1;
        any_d = 1'b1;
      end
    end else if (strkind) begin
      if (!(is_eof_i || (cfg_i.field_kind == sfs_pkg::KIND_STRING && is_sp) ||
            (cfg_i.field_kind == sfs_pkg::KIND_SCANSET && !in_set))) begin
        res_o.consumed = 1'b1;
        if (!cfg_i.suppress_store) begin
          res_o.out_char    = ch_i;
          res_o.char_stored = 1'b1;
        end
        if (wl_str != '0) begin
          body_d = 1'b1;
          wl_d   = wl_str;
          any_d  = 1'b1;
        end else begin
          // width used up on this character, which is consumed
          res_o.field_done = 1'b1;
          res_o.matched    = !cfg_i.suppress_store;
          restart_field    = 1'b1;
        end
      end else begin
        res_o.field_done = 1'b1;
        res_o.matched    = any_q && !cfg_i.suppress_store;
        res_o.at_eof     = is_eof_i;
        restart_field    = 1'b1;
      end
    end else begin
      if (wl != '0 && !is_eof_i && dig_ok) begin
        body_d         = 1'b1;
        wl_d           = wl - 1'b1;
        acc_d          = acc_mul + VALUE_BITS'(dig);
        any_d          = 1'b1;
        res_o.consumed = 1'b1;
      end else begin
        // terminator pushed back; a lone minus still matches as zero
        res_o.field_done = 1'b1;
        res_o.at_eof     = is_eof_i;
        if (any_q && !cfg_i.suppress_store) begin
          res_o.matched = 1'b1;
          res_o.value   = signed'(v32);
        end
        restart_field = 1'b1;
      end
    end
    if (restart_field) begin
      body_d = 1'b0;
      wl_d   = '0;
      acc_d  = '0;
      neg_d  = 1'b0;
      any_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= 1'b0;
      wl_q   <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      any_q  <= 1'b0;
    end else if (restart_i) begin
      body_q <= 1'b0;
      wl_q   <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      any_q  <= 1'b0;
    end else if (step_en_i) begin
      body_q <= body_d;
      wl_q   <= wl_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      any_q  <= any_d;
    end
  end

endmodule
